### hdl/aging_particle_ring_unit_assert.svh
// Assertion macros used by the checker file of the particle ring.
`ifndef AGING_PARTICLE_RING_UNIT_ASSERT_SVH
`define AGING_PARTICLE_RING_UNIT_ASSERT_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define APR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Clocked assertion on the block clock and reset.
`define APR_ASSERT(lbl, prop, msg) \
  `APR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### hdl/apr_pkg.sv
package apr_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);

  // Widths fixed by the stream fields.
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned LIFE_W  = 16;
  localparam int unsigned LMS_W   = 15;
  localparam int unsigned DT_W    = 10;

  // Motion scale 0.0066 held as Q0.24.
  localparam int unsigned KQ      = 110730;
  localparam int unsigned KSHIFT  = 24;
  localparam int unsigned DTK_W   = 27;
  localparam int unsigned PROD_W  = POS_W + DTK_W + 1;
  localparam int unsigned DELTA_W = PROD_W - KSHIFT;
  localparam int unsigned SUM_W   = DELTA_W + 1;

  localparam int unsigned IN_W    = 224;
  localparam int unsigned OUT_W   = 128;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_z;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  vel_z;
    logic signed [POS_W-1:0]  vel_y;
    logic signed [POS_W-1:0]  vel_x;
    logic signed [LIFE_W-1:0] life;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(ENTRIES - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] ring_count(input logic [IDX_W-1:0] tail,
                                                  input logic [IDX_W-1:0] head);
    logic [IDX_W:0] diff;
    if (tail >= head) begin
      diff = {1'b0, tail} - {1'b0, head};
    end else begin
      diff = {1'b0, tail} + (IDX_W + 1)'(ENTRIES) - {1'b0, head};
    end
    return diff[IDX_W-1:0];
  endfunction

endpackage

### hdl/apr_ram.sv
module apr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/aging_particle_ring_unit.sv
// Particle ring: keeps up to ENTRIES-1 particles (position, direction, life) in one
// single-port-read memory. An add request (tuser = 0) writes a particle at the tail,
// dropping the oldest when the ring is full, and gives no result. A tick
// request (tuser = 1) walks the live particles from oldest to newest: per particle it
// reads the entry, decrements life by dt (saturating), retires the head while its life
// is at or below zero, moves each axis by dir * dt * 0.0066 in Q16.16, writes the entry
// back and emits one result; tlast marks the final one. Each particle passes through
// the read, multiply and write-back states in turn (the memory read is registered);
// the write back waits while the result side stalls. New requests are refused while
// a tick walks; the last result of a tick may still wait in the output register while
// the next request is taken. Memory contents are undefined after reset; only entries
// that were written are ever walked.
module aging_particle_ring_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_ms, dt_ms, zero fill
  input  logic [apr_pkg::IN_W-1:0]   s_axis_tdata_i,
  // action
  input  logic                       s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // slot, out_x, out_y, out_z, remaining, live_count, zero fill
  output logic [apr_pkg::OUT_W-1:0]  m_axis_tdata_o,
  output logic                       m_axis_tlast_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_WB
  } state_e;

  localparam int unsigned IW = apr_pkg::IDX_W;
  localparam int unsigned PW = apr_pkg::POS_W;

  state_e                               state_q, state_d;
  logic [IW-1:0]                        head_q, head_d;
  logic [IW-1:0]                        tail_q, tail_d;
  logic [IW-1:0]                        idx_q, idx_d;
  logic [IW-1:0]                        rem_q, rem_d;
  logic [apr_pkg::DT_W-1:0]             dt_q, dt_d;
  logic [apr_pkg::DTK_W-1:0]            dtk_q, dtk_d;
  logic signed [apr_pkg::LIFE_W-1:0]    life_q, life_d;
  logic signed [apr_pkg::PROD_W-1:0]    prod_q [3];
  logic signed [apr_pkg::PROD_W-1:0]    prod_d [3];
  logic                                 m_valid_q, m_valid_d;
  logic                                 m_last_q, m_last_d;
  logic [apr_pkg::OUT_W-1:0]            m_data_q, m_data_d;

  logic                                 ram_we;
  logic [apr_pkg::ADDR_W-1:0]           ram_waddr;
  apr_pkg::entry_t                      ram_wdata;
  logic                                 ram_re;
  logic [apr_pkg::ADDR_W-1:0]           ram_raddr;
  logic [apr_pkg::ENTRY_W-1:0]          ram_rdata;
  apr_pkg::entry_t                      rd_entry;

  logic                                 s_accept;

  apr_ram #(
    .WIDTH (apr_pkg::ENTRY_W),
    .DEPTH (apr_pkg::ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry        = apr_pkg::entry_t'(ram_rdata);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // pos + (prod >>> KSHIFT), clamped to the signed 32-bit range.
  function automatic logic signed [PW-1:0] move_axis(
      input logic signed [PW-1:0]             pos,
      input logic signed [apr_pkg::PROD_W-1:0] prod);
    logic signed [apr_pkg::DELTA_W-1:0] delta;
    logic signed [apr_pkg::SUM_W-1:0]   sum;
    logic signed [PW-1:0]               res;
    delta = prod[apr_pkg::PROD_W-1:apr_pkg::KSHIFT];
    sum   = apr_pkg::SUM_W'(pos) + apr_pkg::SUM_W'(delta);
    if (sum[apr_pkg::SUM_W-1:PW-1] == '0 || sum[apr_pkg::SUM_W-1:PW-1] == '1) begin
      res = sum[PW-1:0];
    end else if (sum[apr_pkg::SUM_W-1]) begin
      res = {1'b1, {(PW-1){1'b0}}};
    end else begin
      res = {1'b0, {(PW-1){1'b1}}};
    end
    return res;
  endfunction

  always_comb begin
    logic [IW-1:0]                     cnt;
    logic signed [apr_pkg::LIFE_W:0]   diff;
    logic signed [PW-1:0]              nx, ny, nz;
    logic [IW-1:0]                     live;
    logic [apr_pkg::DT_W-1:0]          in_dt;

    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    dt_d      = dt_q;
    dtk_d     = dtk_q;
    life_d    = life_q;
    prod_d    = prod_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_last_d  = m_last_q;
    m_data_d  = m_data_q;

    ram_we    = 1'b0;
    ram_waddr = tail_q[apr_pkg::ADDR_W-1:0];
    ram_wdata = rd_entry;
    ram_re    = 1'b0;
    ram_raddr = idx_q[apr_pkg::ADDR_W-1:0];

    cnt   = apr_pkg::ring_count(tail_q, head_q);
    in_dt = s_axis_tdata_i[216:207];
    diff  = '0;
    nx    = '0;
    ny    = '0;
    nz    = '0;
    live  = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser_i == apr_pkg::ACT_ADD) begin
            // Write the new particle at the tail; drop the oldest when full.
            ram_we          = 1'b1;
            ram_waddr       = tail_q[apr_pkg::ADDR_W-1:0];
            ram_wdata.pos_x = s_axis_tdata_i[31:0];
            ram_wdata.pos_y = s_axis_tdata_i[63:32];
            ram_wdata.pos_z = s_axis_tdata_i[95:64];
            ram_wdata.vel_x = s_axis_tdata_i[127:96];
            ram_wdata.vel_y = s_axis_tdata_i[159:128];
            ram_wdata.vel_z = s_axis_tdata_i[191:160];
            ram_wdata.life  = {1'b0, s_axis_tdata_i[206:192]};
            tail_d          = apr_pkg::next_idx(tail_q);
            if (apr_pkg::next_idx(tail_q) == head_q) begin
              head_d = apr_pkg::next_idx(head_q);
            end
          end else if (cnt != '0) begin
            // Latch the walk length and dt * K once per tick.
            rem_d   = cnt;
            idx_d   = head_q;
            dt_d    = in_dt;
            dtk_d   = apr_pkg::DTK_W'({{(apr_pkg::DTK_W - apr_pkg::DT_W){1'b0}}, in_dt}
                      * apr_pkg::DTK_W'(apr_pkg::KQ));
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // Age the entry and form dir * dt * K for each axis.
        diff = (apr_pkg::LIFE_W + 1)'(rd_entry.life)
               - $signed({{(apr_pkg::LIFE_W + 1 - apr_pkg::DT_W){1'b0}}, dt_q});
        if (diff < -(apr_pkg::LIFE_W + 1)'(32768)) begin
          life_d = {1'b1, {(apr_pkg::LIFE_W-1){1'b0}}};
        end else begin
          life_d = diff[apr_pkg::LIFE_W-1:0];
        end
        prod_d[0] = apr_pkg::PROD_W'(rd_entry.vel_x) * $signed({1'b0, dtk_q});
        prod_d[1] = apr_pkg::PROD_W'(rd_entry.vel_y) * $signed({1'b0, dtk_q});
        prod_d[2] = apr_pkg::PROD_W'(rd_entry.vel_z) * $signed({1'b0, dtk_q});
        state_d   = ST_WB;
      end
      ST_WB: begin
        // Hold until the output register is free, then write back and emit.
        if (!m_valid_q || m_axis_tready_i) begin
          nx              = move_axis(rd_entry.pos_x, prod_q[0]);
          ny              = move_axis(rd_entry.pos_y, prod_q[1]);
          nz              = move_axis(rd_entry.pos_z, prod_q[2]);
          ram_we          = 1'b1;
          ram_waddr       = idx_q[apr_pkg::ADDR_W-1:0];
          ram_wdata       = rd_entry;
          ram_wdata.pos_x = nx;
          ram_wdata.pos_y = ny;
          ram_wdata.pos_z = nz;
          ram_wdata.life  = life_q;
          if (life_q <= 0 && idx_q == head_q) begin
            head_d = apr_pkg::next_idx(head_q);
          end
          live      = apr_pkg::ring_count(tail_q, head_d);
          m_valid_d = 1'b1;
          m_last_d  = (rem_q == IW'(1));
          m_data_d  = {4'b0, live, life_q, nz, ny, nx, idx_q};
          rem_d     = rem_q - IW'(1);
          idx_d     = apr_pkg::next_idx(idx_q);
          state_d   = (rem_q == IW'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      idx_q     <= '0;
      rem_q     <= '0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
      dt_q      <= '0;
      dtk_q     <= '0;
      life_q    <= '0;
      prod_q    <= '{default: '0};
      m_data_q  <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      idx_q     <= idx_d;
      rem_q     <= rem_d;
      m_valid_q <= m_valid_d;
      m_last_q  <= m_last_d;
      dt_q      <= dt_d;
      dtk_q     <= dtk_d;
      life_q    <= life_d;
      prod_q    <= prod_d;
      m_data_q  <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

### hdl/apr_checker.sv
`include "aging_particle_ring_unit_assert.svh"

module apr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [apr_pkg::IN_W-1:0]  s_axis_tdata_i,
  input logic                      s_axis_tuser_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [apr_pkg::OUT_W-1:0] m_axis_tdata_o,
  input logic                      m_axis_tlast_o
);

  // Stalled result holds.
  `APR_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "result changed while stalled")

  // Live count and slot stay inside the ring.
  `APR_ASSERT(a_ring_bounds, m_axis_tvalid_o |-> int'(m_axis_tdata_o[123:118]) < apr_pkg::ENTRIES && int'(m_axis_tdata_o[5:0]) < apr_pkg::ENTRIES, "slot or live count out of range")

  // An add never blocks the next request.
  `APR_ASSERT(a_add_ready, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == apr_pkg::ACT_ADD |=> s_axis_tready_o, "add left the block busy")

  // Mid-walk results mean the tick is still running.
  `APR_ASSERT(a_walk_busy, m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o, "request taken during a tick walk")

endmodule

bind aging_particle_ring_unit apr_checker u_apr_checker (.*);
